// File: src/orps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orps_pkg
// Types and constants shared by the overdue-ratio poll scheduler.
// ----------------------------------------------------------------------------
package orps_pkg;

    localparam logic [1:0] REQ_CLEAR   = 2'd0;
    localparam logic [1:0] REQ_APPEND  = 2'd1;
    localparam logic [1:0] REQ_TICK    = 2'd2;
    localparam logic [1:0] REQ_OUTCOME = 2'd3;

    localparam logic [2:0] STS_DONE    = 3'd0;
    localparam logic [2:0] STS_NONE    = 3'd1;
    localparam logic [2:0] STS_UNSUP   = 3'd2;
    localparam logic [2:0] STS_FULL    = 3'd3;
    localparam logic [2:0] STS_BADIDX  = 3'd4;

    localparam logic [1:0] CFG_FAST    = 2'd0;
    localparam logic [1:0] CFG_MEDIUM  = 2'd1;
    localparam logic [1:0] CFG_SLOW    = 2'd2;

    localparam int unsigned QW = 58;
    localparam logic [9:0] US_PER_MS = 10'd1000;
    localparam logic [47:0] MISS_FLOOR_US = 48'd25000;

    typedef struct packed {
        logic [15:0] signal_id;
        logic [25:0] period_us;
        logic [47:0] last_request;
        logic [47:0] last_success;
        logic [31:0] requests;
        logic [31:0] errors;
        logic [31:0] misses;
    } entry_t;

endpackage

// File: src/orps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orps_cell
// One table entry; passes the never-requested search along the chain.
// ----------------------------------------------------------------------------
module orps_cell import orps_pkg::*; (
    input  logic   aclk,
    input  logic   wr_en,
    input  entry_t wr_data,
    input  logic   live,
    input  logic   zero_in,
    output entry_t ent,
    output logic   zero_out,
    output logic   first
);

    entry_t ent_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ent_reg <= wr_data;
        end
    end

    logic fresh;
    assign fresh    = live && (ent_reg.last_request == 48'd0);
    assign first    = fresh && !zero_in;
    assign zero_out = zero_in || fresh;
    assign ent      = ent_reg;

endmodule

// File: src/overdue_ratio_poll_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overdue_ratio_poll_scheduler
// Poll table with tick selection by overdue ratio and outcome bookkeeping.
// ----------------------------------------------------------------------------
// Clear, append and outcome beats finish without leaving ST_IDLE. A tick first
// takes the lowest never-requested entry through the cell chain; otherwise it
// scans the entries one per pass, and each due entry costs a 58-step serial
// divider plus the ST_SCAN, ST_MUL and ST_CMP states. One beat is in work at a time.
module overdue_ratio_poll_scheduler import orps_pkg::*; #(
    parameter int MAX_ENTRIES = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [15:0] s_signal_id,
    input  logic [7:0]  s_priority_req,
    input  logic        s_supported,
    input  logic [47:0] s_now_us,
    input  logic [4:0]  s_entry_index,
    input  logic        s_success,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [4:0]  m_selected_index,
    output logic [15:0] m_selected_id,
    output logic [31:0] m_observed_interval_us,
    output logic [31:0] m_schedule_delay_us,
    output logic        m_deadline_miss,
    output logic [31:0] m_miss_count,
    output logic [31:0] m_request_count,
    output logic [31:0] m_error_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam logic [CW-1:0] FULL = CW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE, ST_PICK, ST_SCAN, ST_MUL, ST_DIV, ST_CMP, ST_TIME, ST_OUT
    } state_t;

    function automatic logic [31:0] sat32(input logic [47:0] v);
        return (v[47:32] != 16'd0) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    state_t        state_reg;
    logic [15:0]   fast_reg, medium_reg, slow_reg;
    logic [CW-1:0] count_reg;
    logic [47:0]   now_reg;
    logic [CW-1:0] scan_reg;
    logic [IW-1:0] win_reg;
    logic          have_reg;
    logic [QW-1:0] top_reg;
    logic [47:0]   el_reg;
    logic [QW-1:0] quo_reg;
    logic [26:0]   rem_reg;
    logic [5:0]    step_reg;
    logic [47:0]   obs_reg, dly_reg;

    logic          m_valid_reg;
    logic [2:0]    status_reg;
    logic [4:0]    sel_idx_reg;
    logic [15:0]   sel_id_reg;
    logic [31:0]   obs_out_reg, dly_out_reg, miss_out_reg, req_out_reg, err_out_reg;
    logic          miss_flag_reg;

    entry_t              ents [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] wr_en;
    logic [MAX_ENTRIES-1:0] first_vec;
    logic [MAX_ENTRIES:0]   zchain;
    entry_t              wr_data;

    assign zchain[0] = 1'b0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        orps_cell u_cell (
            .aclk    (aclk),
            .wr_en   (wr_en[g]),
            .wr_data (wr_data),
            .live    (count_reg > CW'(g)),
            .zero_in (zchain[g]),
            .ent     (ents[g]),
            .zero_out(zchain[g+1]),
            .first   (first_vec[g])
        );
    end

    logic [IW-1:0] first_idx;
    always_comb begin
        first_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (first_vec[i]) begin
                first_idx = first_idx | IW'(i);
            end
        end
    end

    logic        out_free;
    logic        accept;
    logic        m_set;
    logic [15:0] class_ms;
    logic [25:0] class_per;
    entry_t      out_ent, scan_ent, win_ent;
    logic [26:0] div_r;
    logic        div_ge;
    logic [51:0] dly_x10;
    logic        miss;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_set     = (accept && s_req_type != REQ_TICK) || (state_reg == ST_OUT && out_free);

    assign out_ent  = ents[s_entry_index[IW-1:0]];
    assign scan_ent = ents[scan_reg[IW-1:0]];
    assign win_ent  = ents[win_reg];

    always_comb begin
        case (s_priority_req)
            8'd0:    class_ms = fast_reg;
            8'd1:    class_ms = medium_reg;
            default: class_ms = slow_reg;
        endcase
        if (class_ms == 16'd0) begin
            class_ms = 16'd1;
        end
    end
    assign class_per = {10'd0, class_ms} * {16'd0, US_PER_MS};

    assign div_r   = {rem_reg[25:0], quo_reg[QW-1]};
    assign div_ge  = div_r >= {1'b0, scan_ent.period_us};
    assign dly_x10 = {1'b0, dly_reg, 3'd0} + {3'd0, dly_reg, 1'b0};
    assign miss    = (dly_x10 > {26'd0, win_ent.period_us}) && (dly_reg > MISS_FLOOR_US);

    always_comb begin
        wr_en   = '0;
        wr_data = out_ent;
        if (accept && s_req_type == REQ_APPEND && s_supported && count_reg < FULL) begin
            wr_en[count_reg[IW-1:0]] = 1'b1;
            wr_data = '{signal_id: s_signal_id, period_us: class_per,
                        last_request: 48'd0, last_success: 48'd0,
                        requests: 32'd0, errors: 32'd0, misses: 32'd0};
        end else if (accept && s_req_type == REQ_OUTCOME
                     && {1'b0, s_entry_index} < 6'(count_reg)) begin
            wr_en[s_entry_index[IW-1:0]] = 1'b1;
            if (s_success) begin
                wr_data.last_success = s_now_us;
            end else begin
                wr_data.errors = out_ent.errors + 32'd1;
            end
        end else if (state_reg == ST_OUT && out_free && have_reg) begin
            wr_en[win_reg] = 1'b1;
            wr_data = win_ent;
            wr_data.last_request = now_reg;
            wr_data.requests = win_ent.requests + 32'd1;
            wr_data.misses = win_ent.misses + {31'd0, miss};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fast_reg    <= 16'd100;
            medium_reg  <= 16'd500;
            slow_reg    <= 16'd2000;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_FAST:   fast_reg   <= cfg_data;
                    CFG_MEDIUM: medium_reg <= cfg_data;
                    CFG_SLOW:   slow_reg   <= cfg_data;
                    default:    ;
                endcase
            end
            if (m_valid_reg && m_ready && !m_set) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        status_reg    <= STS_DONE;
                        sel_idx_reg   <= 5'd0;
                        sel_id_reg    <= 16'd0;
                        obs_out_reg   <= 32'd0;
                        dly_out_reg   <= 32'd0;
                        miss_flag_reg <= 1'b0;
                        miss_out_reg  <= 32'd0;
                        req_out_reg   <= 32'd0;
                        err_out_reg   <= 32'd0;
                        now_reg       <= s_now_us;
                        case (s_req_type)
                            REQ_CLEAR: begin
                                count_reg   <= '0;
                                m_valid_reg <= 1'b1;
                            end
                            REQ_APPEND: begin
                                sel_id_reg  <= s_signal_id;
                                m_valid_reg <= 1'b1;
                                if (!s_supported) begin
                                    status_reg <= STS_UNSUP;
                                end else if (count_reg >= FULL) begin
                                    status_reg <= STS_FULL;
                                end else begin
                                    count_reg   <= count_reg + CW'(1);
                                    sel_idx_reg <= 5'(count_reg);
                                    obs_out_reg <= {6'd0, class_per};
                                end
                            end
                            REQ_TICK: begin
                                state_reg <= ST_PICK;
                            end
                            default: begin
                                m_valid_reg <= 1'b1;
                                if ({1'b0, s_entry_index} >= 6'(count_reg)) begin
                                    status_reg <= STS_BADIDX;
                                end else begin
                                    sel_idx_reg  <= s_entry_index;
                                    sel_id_reg   <= out_ent.signal_id;
                                    miss_out_reg <= out_ent.misses;
                                    req_out_reg  <= out_ent.requests;
                                    err_out_reg  <= s_success ? out_ent.errors
                                                              : out_ent.errors + 32'd1;
                                end
                            end
                        endcase
                    end
                end
                ST_PICK: begin
                    scan_reg <= '0;
                    top_reg  <= '0;
                    if (zchain[MAX_ENTRIES]) begin
                        win_reg   <= first_idx;
                        have_reg  <= 1'b1;
                        state_reg <= ST_TIME;
                    end else begin
                        have_reg  <= 1'b0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_reg >= count_reg) begin
                        state_reg <= ST_TIME;
                    end else begin
                        el_reg <= (now_reg >= scan_ent.last_request)
                                  ? now_reg - scan_ent.last_request : 48'd0;
                        if (now_reg >= scan_ent.last_request
                            && now_reg - scan_ent.last_request >= {22'd0, scan_ent.period_us}) begin
                            state_reg <= ST_MUL;
                        end else begin
                            scan_reg <= scan_reg + CW'(1);
                        end
                    end
                end
                ST_MUL: begin
                    quo_reg   <= {10'd0, el_reg} * {48'd0, US_PER_MS};
                    rem_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    rem_reg  <= div_ge ? div_r - {1'b0, scan_ent.period_us} : div_r;
                    quo_reg  <= {quo_reg[QW-2:0], div_ge};
                    step_reg <= step_reg + 6'd1;
                    if (step_reg == 6'(QW - 1)) begin
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP: begin
                    if (quo_reg > top_reg) begin
                        top_reg  <= quo_reg;
                        win_reg  <= scan_reg[IW-1:0];
                        have_reg <= 1'b1;
                    end
                    scan_reg  <= scan_reg + CW'(1);
                    state_reg <= ST_SCAN;
                end
                ST_TIME: begin
                    if (win_ent.last_request != 48'd0) begin
                        obs_reg <= (now_reg >= win_ent.last_request)
                                   ? now_reg - win_ent.last_request
                                   : {22'd0, win_ent.period_us};
                        dly_reg <= (now_reg > win_ent.last_request + {22'd0, win_ent.period_us})
                                   ? now_reg - win_ent.last_request - {22'd0, win_ent.period_us}
                                   : 48'd0;
                    end else begin
                        obs_reg <= {22'd0, win_ent.period_us};
                        dly_reg <= 48'd0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                        if (!have_reg) begin
                            status_reg <= STS_NONE;
                        end else begin
                            status_reg    <= STS_DONE;
                            sel_idx_reg   <= 5'(win_reg);
                            sel_id_reg    <= win_ent.signal_id;
                            obs_out_reg   <= sat32(obs_reg);
                            dly_out_reg   <= sat32(dly_reg);
                            miss_flag_reg <= miss;
                            miss_out_reg  <= win_ent.misses + {31'd0, miss};
                            req_out_reg   <= win_ent.requests + 32'd1;
                            err_out_reg   <= win_ent.errors;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_status               = status_reg;
    assign m_selected_index       = sel_idx_reg;
    assign m_selected_id          = sel_id_reg;
    assign m_observed_interval_us = obs_out_reg;
    assign m_schedule_delay_us    = dly_out_reg;
    assign m_deadline_miss        = miss_flag_reg;
    assign m_miss_count           = miss_out_reg;
    assign m_request_count        = req_out_reg;
    assign m_error_count          = err_out_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL)
        else $error("entry count above capacity");

    a_tick_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_req_type == REQ_TICK |=> state_reg == ST_PICK && !s_ready)
        else $error("tick beat did not start a selection");

    a_one_write: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(wr_en))
        else $error("more than one cell written");

    a_done_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_OUT && out_free |=> m_valid && state_reg == ST_IDLE)
        else $error("tick result not presented");

endmodule
